// File: design/captive_dns_responder_core_assert.svh
// Assertion macros used by the checker file of the DNS responder.
`ifndef CAPTIVE_DNS_RESPONDER_CORE_ASSERT_SVH
`define CAPTIVE_DNS_RESPONDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdr assertion failed");

`endif

// File: design/cdr_pkg.sv
// Types and constants of the captive DNS responder.
package cdr_pkg;

    localparam int HDR_LEN   = 12;
    localparam int ANS_LEN   = 16;
    localparam int OUT_BYTES = 512;
    localparam int IDXW      = 9;
    localparam int LENW      = 10;

    localparam logic [7:0] FLAGS_HI  = 8'h81;
    localparam logic [7:0] FLAGS_LO  = 8'h80;
    localparam logic [7:0] PTR_HI    = 8'hC0;
    localparam logic [7:0] PTR_LO    = 8'h0C;
    localparam logic [7:0] TTL_SECS  = 8'h3C;
    localparam logic [7:0] RDATA_LEN = 8'h04;

    typedef struct packed {
        logic            vld;
        logic            from_store;
        logic            last;
        logic [IDXW-1:0] idx;
        logic [3:0]      ans_off;
    } t_emit;

endpackage

// File: design/cdr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/cdr_packer.sv
// Reply byte formatter and 64-bit word packer with registered outputs.
module cdr_packer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cdr_pkg::t_emit i_emit,
    input  logic [7:0]    i_rdata,
    input  logic [31:0]   i_redirect,
    output logic          o_strobe,
    output logic [63:0]   o_reply_word,
    output logic [3:0]    o_valid_bytes,
    output logic          o_last_word
);
    import cdr_pkg::*;

    logic [7:0]  w_byte;
    logic [2:0]  w_slot;
    logic [63:0] w_acc;
    logic        w_flush;

    logic [63:0] r_acc;
    logic        r_strobe;
    logic [63:0] r_word;
    logic [3:0]  r_vb;
    logic        r_last;

    always_comb begin
        w_byte = i_rdata;
        if (i_emit.from_store) begin
            case (i_emit.idx)
                IDXW'(2):  w_byte = FLAGS_HI;
                IDXW'(3):  w_byte = FLAGS_LO;
                IDXW'(6):  w_byte = 8'h00;
                IDXW'(7):  w_byte = 8'h01;
                IDXW'(8):  w_byte = 8'h00;
                IDXW'(9):  w_byte = 8'h00;
                IDXW'(10): w_byte = 8'h00;
                IDXW'(11): w_byte = 8'h00;
                default:   w_byte = i_rdata;
            endcase
        end else begin
            case (i_emit.ans_off)
                4'd0:    w_byte = PTR_HI;
                4'd1:    w_byte = PTR_LO;
                4'd3:    w_byte = 8'h01;
                4'd5:    w_byte = 8'h01;
                4'd9:    w_byte = TTL_SECS;
                4'd11:   w_byte = RDATA_LEN;
                4'd12:   w_byte = i_redirect[31:24];
                4'd13:   w_byte = i_redirect[23:16];
                4'd14:   w_byte = i_redirect[15:8];
                4'd15:   w_byte = i_redirect[7:0];
                default: w_byte = 8'h00;
            endcase
        end
    end

    assign w_slot  = i_emit.idx[2:0];
    assign w_acc   = ((w_slot == 3'd0) ? 64'd0 : r_acc) |
                     ({56'd0, w_byte} << {~w_slot, 3'b000});
    assign w_flush = i_emit.vld && ((w_slot == 3'd7) || i_emit.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_flush;
        end
        if (i_emit.vld) begin
            r_acc <= w_acc;
        end
        if (w_flush) begin
            r_word <= w_acc;
            r_vb   <= {1'b0, w_slot} + 4'd1;
            r_last <= i_emit.last;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_reply_word  = r_word;
    assign o_valid_bytes = r_vb;
    assign o_last_word   = r_last;

endmodule

// File: design/captive_dns_responder_core.sv
// Captive DNS responder: query store, validation walk and reply sequencer.
// Query bytes are taken one per cycle; busy stays low until the end mark.
// After the end mark: a check state, then a walk state and a read-check state per name label,
// a length-check state, then one reply byte per cycle from the store read port or constants;
// each reply word is registered at the packer output.
// Synchronous reset clears control state and the address register; the store is not cleared.
module captive_dns_responder_core #(
    parameter int MAX_LEN = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_end_of_packet,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        strobe,
    output logic [63:0] o_reply_word,
    output logic [3:0]  o_valid_bytes,
    output logic        o_last_word
);
    import cdr_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(MAX_LEN + 512);

    localparam logic [2:0] S_RECV = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_WRD  = 3'd2;
    localparam logic [2:0] S_WCHK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_n, n_n;
    logic [7:0]      r_q4, n_q4;
    logic [7:0]      r_q5, n_q5;
    logic [PW-1:0]   r_p, n_p;
    logic [LENW-1:0] r_qend, n_qend;
    logic [LENW-1:0] r_len, n_len;
    logic [LENW-1:0] r_idx, n_idx;
    t_emit           r_emit, n_emit;
    logic [31:0]     r_redirect;

    logic            w_acc;
    logic            w_we;
    logic [AW-1:0]   w_raddr;
    logic [7:0]      w_rdata;
    logic [PW-1:0]   w_qend;
    logic [PW-1:0]   w_rlen;

    assign busy   = (r_state != S_RECV);
    assign w_acc  = start && !busy;
    assign w_we   = w_acc && (r_cnt < CW'(MAX_LEN));
    assign w_qend = r_p + PW'(5);
    assign w_rlen = w_qend + PW'(ANS_LEN);
    assign w_raddr = (r_state == S_EMIT) ? AW'(r_idx) : AW'(r_p);

    cdr_ram #(
        .WIDTH(8),
        .DEPTH(MAX_LEN)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(AW'(r_cnt)),
        .i_wdata(i_payload_byte),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_q4    = r_q4;
        n_q5    = r_q5;
        n_p     = r_p;
        n_qend  = r_qend;
        n_len   = r_len;
        n_idx   = r_idx;
        n_emit  = '0;
        case (r_state)
            S_RECV: begin
                if (w_acc) begin
                    if (w_we) begin
                        n_cnt = r_cnt + CW'(1);
                        if (r_cnt == CW'(4)) begin
                            n_q4 = i_payload_byte;
                        end
                        if (r_cnt == CW'(5)) begin
                            n_q5 = i_payload_byte;
                        end
                    end
                    if (i_end_of_packet) begin
                        n_n     = n_cnt;
                        n_cnt   = '0;
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_p = PW'(HDR_LEN);
                if ((r_n < CW'(HDR_LEN)) || (r_q4 != 8'h00) || (r_q5 != 8'h01)) begin
                    n_state = S_RECV;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                if (r_p < PW'(r_n)) begin
                    n_state = S_WCHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WCHK: begin
                if (w_rdata == 8'h00) begin
                    n_state = S_FIN;
                end else begin
                    n_p     = r_p + PW'(w_rdata) + PW'(1);
                    n_state = S_WRD;
                end
            end
            S_FIN: begin
                n_qend = LENW'(w_qend);
                n_len  = LENW'(w_rlen);
                n_idx  = '0;
                if ((w_qend > PW'(r_n)) || (w_rlen > PW'(MAX_LEN)) ||
                    (w_rlen > PW'(OUT_BYTES))) begin
                    n_state = S_RECV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_idx < r_len) begin
                    n_emit.vld        = 1'b1;
                    n_emit.from_store = (r_idx < r_qend);
                    n_emit.last       = (r_idx == (r_len - LENW'(1)));
                    n_emit.idx        = IDXW'(r_idx);
                    n_emit.ans_off    = 4'(r_idx - r_qend);
                    n_idx             = r_idx + LENW'(1);
                end
                if (r_emit.vld && r_emit.last) begin
                    n_state = S_RECV;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RECV;
            r_cnt      <= '0;
            r_emit     <= '0;
            r_redirect <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_emit  <= n_emit;
            if (i_cfg_we) begin
                r_redirect <= i_cfg_wdata;
            end
        end
        r_n    <= n_n;
        r_q4   <= n_q4;
        r_q5   <= n_q5;
        r_p    <= n_p;
        r_qend <= n_qend;
        r_len  <= n_len;
        r_idx  <= n_idx;
    end

    cdr_packer u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit       (r_emit),
        .i_rdata      (w_rdata),
        .i_redirect   (r_redirect),
        .o_strobe     (strobe),
        .o_reply_word (o_reply_word),
        .o_valid_bytes(o_valid_bytes),
        .o_last_word  (o_last_word)
    );

endmodule

// File: design/cdr_checker.sv
// Port-level checker for the captive DNS responder and its bind statement.
`include "captive_dns_responder_core_assert.svh"

module cdr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       i_busy,
    input logic       i_end_of_packet,
    input logic       i_strobe,
    input logic [3:0] i_valid_bytes,
    input logic       i_last_word
);

    `CDR_ASSERT_IMP(a_vb_range, i_clk, i_rst_n, i_strobe, (i_valid_bytes != 4'd0) && (i_valid_bytes <= 4'd8))
    `CDR_ASSERT_IMP(a_short_is_last, i_clk, i_rst_n, i_strobe && (i_valid_bytes != 4'd8), i_last_word)
    `CDR_ASSERT_IMP(a_mid_word_busy, i_clk, i_rst_n, i_strobe && !i_last_word, i_busy)
    `CDR_ASSERT_IMP(a_last_word_idle, i_clk, i_rst_n, i_strobe && i_last_word, !i_busy)
    `CDR_ASSERT_NXT(a_eop_goes_busy, i_clk, i_rst_n, i_start && !i_busy && i_end_of_packet, i_busy)

endmodule

bind captive_dns_responder_core cdr_checker u_cdr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (start),
    .i_busy         (busy),
    .i_end_of_packet(i_end_of_packet),
    .i_strobe       (strobe),
    .i_valid_bytes  (o_valid_bytes),
    .i_last_word    (o_last_word)
);

// File: sim/tb.sv
// Self-checking testbench for the captive DNS responder core.

localparam int QUERY_MAX   = 512;
localparam int STALL_LIMIT = 4000;

typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last_flag;
} reply_word_t;

class dns_reply_scoreboard;
    logic [7:0]  query_bytes [QUERY_MAX];
    int          stored;
    logic [31:0] answer_ip;
    reply_word_t expected_words[$];
    int          errors;
    int          queries;
    int          answered;
    int          dropped;
    int          words_checked;

    function new();
        stored = 0;
        answer_ip = '0;
        errors = 0;
        queries = 0;
        answered = 0;
        dropped = 0;
        words_checked = 0;
    endfunction

    function void set_answer_ip(logic [31:0] ip);
        answer_ip = ip;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    function void note_request(logic [7:0] b, logic eop);
        int n, p, qend, len, nwords, cnt, i, off;
        logic [63:0] w;
        logic [7:0]  rb;
        reply_word_t e;
        if (stored < QUERY_MAX) begin
            query_bytes[stored] = b;
            stored++;
        end
        if (!eop) return;
        n = stored;
        stored = 0;
        queries++;
        if (n < cdr_pkg::HDR_LEN || query_bytes[4] != 8'h00 || query_bytes[5] != 8'h01) begin
            dropped++;
            return;
        end
        // The name is a chain of length-prefixed labels ended by a zero byte.
        p = cdr_pkg::HDR_LEN;
        while (p < n && query_bytes[p] != 8'h00) begin
            p += int'(query_bytes[p]) + 1;
        end
        qend = p + 5;
        len = qend + cdr_pkg::ANS_LEN;
        if (qend > n || len > QUERY_MAX || len > cdr_pkg::OUT_BYTES) begin
            dropped++;
            return;
        end
        answered++;
        nwords = (len + 7) / 8;
        for (int k = 0; k < nwords; k++) begin
            w = '0;
            cnt = (len - 8 * k > 8) ? 8 : len - 8 * k;
            for (int j = 0; j < 8; j++) begin
                i = 8 * k + j;
                rb = 8'h00;
                if (j >= cnt) begin
                    rb = 8'h00;
                end else if (i < qend) begin
                    case (i)
                        2: rb = cdr_pkg::FLAGS_HI;
                        3: rb = cdr_pkg::FLAGS_LO;
                        7: rb = 8'h01;
                        6, 8, 9, 10, 11: rb = 8'h00;
                        default: rb = query_bytes[i];
                    endcase
                end else begin
                    off = i - qend;
                    case (off)
                        0: rb = cdr_pkg::PTR_HI;
                        1: rb = cdr_pkg::PTR_LO;
                        3, 5: rb = 8'h01;
                        9: rb = cdr_pkg::TTL_SECS;
                        11: rb = cdr_pkg::RDATA_LEN;
                        12, 13, 14, 15: rb = answer_ip[8 * (15 - off) +: 8];
                        default: rb = 8'h00;
                    endcase
                end
                w = {w[55:0], rb};
            end
            e.word = w;
            e.nbytes = 4'(cnt);
            e.last_flag = (k == nwords - 1);
            expected_words.push_back(e);
        end
    endfunction

    function void check_word(logic [63:0] w, logic [3:0] nb, logic last_flag);
        reply_word_t e;
        words_checked++;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected reply word %h (bytes %0d, last %b)", $time, w, nb, last_flag);
            errors++;
            return;
        end
        e = expected_words.pop_front();
        if (w !== e.word) begin
            $display("%0t: reply_word expected %h actual %h", $time, e.word, w);
            errors++;
        end
        if (nb !== e.nbytes) begin
            $display("%0t: valid_bytes expected %0d actual %0d", $time, e.nbytes, nb);
            errors++;
        end
        if (last_flag !== e.last_flag) begin
            $display("%0t: last_word expected %b actual %b", $time, e.last_flag, last_flag);
            errors++;
        end
    endfunction
endclass

module tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_payload_byte = '0;
    logic        i_end_of_packet = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        strobe;
    logic [63:0] o_reply_word;
    logic [3:0]  o_valid_bytes;
    logic        o_last_word;

    dns_reply_scoreboard sb = new();
    logic [7:0] pkt[$];
    int         bytes_sent = 0;
    int         ip_writes = 0;
    int         stall_cycles = 0;

    captive_dns_responder_core #(
        .MAX_LEN(QUERY_MAX)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_payload_byte(i_payload_byte),
        .i_end_of_packet(i_end_of_packet),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .strobe(strobe),
        .o_reply_word(o_reply_word),
        .o_valid_bytes(o_valid_bytes),
        .o_last_word(o_last_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && strobe) begin
            sb.check_word(o_reply_word, o_valid_bytes, o_last_word);
        end
        if ((start && !busy) || strobe || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: %0d cycles without any request or reply.", stall_cycles);
            $display("FAIL captive_dns_responder_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_bytes(int count);
        repeat (count) pkt.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void begin_query(logic [15:0] qdcount);
        pkt.delete();
        add_bytes(4);
        pkt.push_back(qdcount[15:8]);
        pkt.push_back(qdcount[7:0]);
        add_bytes(6);
    endfunction

    // Appends labels that take up total bytes (two when total is one), then the terminating zero byte.
    function automatic void add_name(int total);
        int rem, len;
        rem = (total == 1) ? 2 : total;
        while (rem > 0) begin
            len = $urandom_range(1, 63);
            if (len > rem - 1) len = rem - 1;
            if (rem - (len + 1) == 1) len = (len > 1) ? len - 1 : len + 1;
            pkt.push_back(8'(len));
            add_bytes(len);
            rem -= len + 1;
        end
        pkt.push_back(8'h00);
    endfunction

    task automatic send_packet();
        int  gap;
        bit  no_idle;
        logic eop;
        no_idle = ($urandom_range(0, 3) == 0);
        foreach (pkt[i]) begin
            eop = (i == pkt.size() - 1);
            start <= 1'b1;
            i_payload_byte <= pkt[i];
            i_end_of_packet <= eop;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            sb.note_request(pkt[i], eop);
            bytes_sent++;
            gap = no_idle ? 0 : pick_gap();
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_answer_ip(logic [31:0] ip);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= ip;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_answer_ip(ip);
        ip_writes++;
    endtask

    initial begin
        int kind, target, total;
        logic [15:0] qd;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_answer_ip(32'hFFFF_FFFF);
        begin_query(16'h0001); add_name(0); add_bytes(4); send_packet();
        begin_query(16'h0001); add_name(16); add_bytes(4); add_bytes(11); send_packet();
        pkt.delete(); add_bytes(11); send_packet();
        begin_query(16'h0001); send_packet();
        pkt.delete(); pkt.push_back(8'hFF); send_packet();
        begin_query(16'h0002); add_name(8); add_bytes(4); send_packet();
        begin_query(16'h0101); add_name(8); add_bytes(4); send_packet();
        begin_query(16'h0000); add_name(8); add_bytes(4); send_packet();
        begin_query(16'h0001); pkt.push_back(8'd200); add_bytes(20); send_packet();
        begin_query(16'h0001); pkt.push_back(8'hC0); add_bytes(3); send_packet();
        begin_query(16'h0001); add_name(0); add_bytes(3); send_packet();

        write_answer_ip(32'h0000_0000);
        begin_query(16'h0001); add_name(20); add_bytes(4); send_packet();
        write_answer_ip(32'h8000_0001);
        begin_query(16'h0001); add_name(5); add_bytes(4); send_packet();

        target = 400;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 5) == 0) write_answer_ip($urandom);
            kind = $urandom_range(0, 9);
            total = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
            if (kind <= 6) begin
                begin_query(16'h0001);
                add_name(total);
                add_bytes(4);
                if ($urandom_range(0, 2) == 0) add_bytes($urandom_range(1, 8));
            end else if (kind == 7) begin
                qd = 16'($urandom);
                if (qd == 16'h0001) qd = 16'h0002;
                begin_query(qd);
                add_name($urandom_range(0, 20));
                add_bytes(4);
            end else if (kind == 8) begin
                begin_query(16'h0001);
                add_name(total);
                add_bytes(4);
                repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
            end else begin
                pkt.delete();
                add_bytes($urandom_range(1, 40));
                if (pkt.size() >= 6 && $urandom_range(0, 1) == 0) begin
                    pkt[4] = 8'h00;
                    pkt[5] = 8'h01;
                end
            end
            send_packet();
        end

        wait_idle();
        repeat (600) @(posedge i_clk);
        $display("Sent %0d query bytes in %0d queries: %0d answered, %0d dropped.",
                 bytes_sent, sb.queries, sb.answered, sb.dropped);
        $display("Checked %0d reply words over %0d answer address settings.",
                 sb.words_checked, ip_writes);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected reply words never arrived", $time, sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS captive_dns_responder_core");
        end else begin
            $display("FAIL captive_dns_responder_core");
        end
        $finish;
    end
endmodule
